// ===== hw/rtl/dns_name_label_encoder_defines.svh =====
// Assertion macros shared by the DNS name label encoder RTL.
`ifndef DNS_NAME_LABEL_ENCODER_DEFINES_SVH
`define DNS_NAME_LABEL_ENCODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DNLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DNLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/dnle_pkg.sv =====
// Types and constants of the DNS name label encoder.
package dnle_pkg;

  localparam logic [7:0] DOT_CHAR    = 8'd46;
  localparam logic [7:0] TERM_BYTE   = 8'd0;
  localparam int         STORE_DEPTH = 62;
  localparam int         CNT_W       = 6;
  localparam int         ADDR_W      = 6;
  localparam int         QDEPTH      = 4;
  localparam int         PTR_W       = 2;
  localparam int         FILL_W      = 3;

  typedef enum logic [1:0] {
    CMD_BUFFER,        // ordinary character inside a name
    CMD_CLOSE,         // dot inside a name
    CMD_FINISH,        // dot that ends the name
    CMD_BUFFER_FINISH  // ordinary character that ends the name
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_CHAR,
    ST_TERM
  } back_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
  } back_status_t;

endpackage

// ===== hw/rtl/dns_name_label_encoder.sv =====
// Encodes a dotted host name, one character per request, into DNS wire
// format: each label becomes a length byte followed by its characters, and
// the end of the name adds a zero terminator. A front end classifies each
// character and places it in a four-entry command queue; the back end owns a
// 62-byte label store with one registered read port and a one-entry result
// register. The back end takes each command from the queue in its idle state;
// an ordinary character is only stored there, while a dot or the end of the
// name then emits the length byte and the label characters (and the terminator
// at the end of the name), one result byte per cycle while the result register
// is free or being popped. Labels longer than MAX_LABEL keep their first MAX_LABEL
// characters and their length byte carries label_overflow.
module dns_name_label_encoder import dnle_pkg::*; #(
  parameter int MAX_LABEL = 62
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char,
  input  logic       name_end,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       label_overflow
);

`include "dns_name_label_encoder_defines.svh"

  cmd_t         cmd;
  logic         cmd_valid;
  logic         cmd_ready;
  back_status_t status;

  dnle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_char   (in_char),
    .name_end  (name_end),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  dnle_back #(
    .MAX_LABEL (MAX_LABEL)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .run_last       (run_last),
    .label_overflow (label_overflow),
    .status         (status)
  );

  `DNLE_ASSERT_NEXT(a_accept_queued, clk, rst, push && !full, cmd_valid, "accepted request not queued")
  `DNLE_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, status.count <= CNT_W'(MAX_LABEL), "label count above limit")
  `DNLE_ASSERT_SAME(a_ovf_full, clk, rst, status.ovf, status.count == CNT_W'(MAX_LABEL), "overflow with label not full")
  `DNLE_ASSERT_SAME(a_ovf_len, clk, rst, !empty && label_overflow, out_byte == 8'(MAX_LABEL), "overflow flag on wrong length")

endmodule

// ===== hw/rtl/dnle_front.sv =====
// Front end: accepts characters, classifies them and queues commands.
module dnle_front import dnle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char,
  input  logic       name_end,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_ready
);

  cmd_t              q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;
  cmd_t              new_cmd;

  always_comb begin
    new_cmd.ch = in_char;
    unique case ({in_char == DOT_CHAR, name_end})
      2'b00:   new_cmd.kind = CMD_BUFFER;
      2'b01:   new_cmd.kind = CMD_BUFFER_FINISH;
      2'b10:   new_cmd.kind = CMD_CLOSE;
      2'b11:   new_cmd.kind = CMD_FINISH;
      default: new_cmd.kind = CMD_BUFFER;
    endcase
  end

  assign full      = (fill == FILL_W'(QDEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dnle_back.sv =====
// Back end: label buffer, length and terminator emission, result register.
module dnle_back import dnle_pkg::*; #(
  parameter int MAX_LABEL = 62
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  input  logic         pop,
  output logic         empty,
  output logic [7:0]   out_byte,
  output logic         run_last,
  output logic         label_overflow,
  output back_status_t status
);

  back_state_t      state;
  back_state_t      state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             ovf;
  logic             ovf_next;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] idx_next;
  logic [ADDR_W-1:0] idx_inc;
  logic             fin;
  logic             fin_next;
  logic [7:0]       mem [STORE_DEPTH];
  logic [7:0]       mem_q;
  logic             wr_en;
  logic             out_valid;
  logic             can_emit;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic             emit_ovf;
  logic             take_buf;

  assign empty    = !out_valid;
  assign can_emit = !out_valid || pop;
  assign idx_inc  = idx + 1'b1;
  assign take_buf = (cmd.kind == CMD_BUFFER) || (cmd.kind == CMD_BUFFER_FINISH);
  assign status.count = count;
  assign status.ovf   = ovf;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.kind != CMD_BUFFER) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        if (can_emit) begin
          if (count == '0) begin
            state_next = fin ? ST_TERM : ST_IDLE;
          end else begin
            state_next = ST_CHAR;
          end
        end
      end
      ST_CHAR: begin
        if (can_emit && idx_inc == count) begin
          state_next = fin ? ST_TERM : ST_IDLE;
        end
      end
      ST_TERM: begin
        if (can_emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready  = 1'b0;
    wr_en      = 1'b0;
    emit       = 1'b0;
    emit_byte  = TERM_BYTE;
    emit_last  = 1'b0;
    emit_ovf   = 1'b0;
    count_next = count;
    ovf_next   = ovf;
    idx_next   = idx;
    fin_next   = fin;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        idx_next  = '0;
        if (cmd_valid) begin
          fin_next = (cmd.kind == CMD_FINISH) || (cmd.kind == CMD_BUFFER_FINISH);
          if (take_buf) begin
            if (count < CNT_W'(MAX_LABEL)) begin
              wr_en      = 1'b1;
              count_next = count + 1'b1;
            end else begin
              ovf_next = 1'b1;
            end
          end
        end
      end
      ST_LEN: begin
        // The store is read again here so that a character written on the
        // previous cycle is seen by the first character cycle.
        idx_next = '0;
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = {{(8 - CNT_W){1'b0}}, count};
          emit_ovf  = ovf;
          emit_last = (count == '0) && !fin;
          if (count == '0) begin
            ovf_next = 1'b0;
          end
        end
      end
      ST_CHAR: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = mem_q;
          emit_last = (idx_inc == count) && !fin;
          idx_next  = idx_inc;
          if (idx_inc == count) begin
            count_next = '0;
            ovf_next   = 1'b0;
          end
        end
      end
      ST_TERM: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = TERM_BYTE;
          emit_last = 1'b1;
        end
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count] <= cmd.ch;
    end
    mem_q <= mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte       <= emit_byte;
      run_last       <= emit_last;
      label_overflow <= emit_ovf;
    end
    idx <= idx_next;
    fin <= fin_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
